@@ rtl/chpf_pkg.sv @@
// Shared widths, register indexes and status types of the cascaded high-pass filter.
package chpf_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int ALPHA_W    = 16;
    localparam int COUNT_W    = 3;
    localparam int ACC_W      = 32;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = 34;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd1;

    // Saturation limits.
    localparam logic signed [ACC_W-1:0]    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Status of the digit-serial multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

@@ rtl/chpf_stream_if.sv @@
// Valid/ready stream interfaces for the input and result sample channels.
interface chpf_sample_in_if;
    import chpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface chpf_sample_out_if;
    import chpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

@@ rtl/chpf_digit_mul.sv @@
// Digit-serial signed by unsigned multiplier returning floor(product / 2^ALPHA_W) and a sticky bit.
module chpf_digit_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [chpf_pkg::SUM_W-1:0]   multiplicand,
    input  logic        [chpf_pkg::ALPHA_W-1:0] multiplier,
    output chpf_pkg::mul_status_t               status,
    output logic signed [chpf_pkg::SUM_W-1:0]   quotient,
    output logic                                sticky
);
    import chpf_pkg::*;

    localparam int STEPS  = ALPHA_W / DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int T_W    = SUM_W + DIGIT_W + 1;

    logic signed [SUM_W-1:0]   mcand_reg;
    logic        [ALPHA_W-1:0] mplier_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic                      sticky_reg;
    logic        [STEP_W-1:0]  step_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic        [DIGIT_W-1:0] digit;
    logic signed [T_W-1:0]     partial;
    logic signed [T_W-1:0]     total;
    logic signed [SUM_W-1:0]   acc_next;
    logic                      sticky_next;

    // One multiplier digit per cycle, least significant first; the low digit
    // of each partial sum drops out into the sticky bit.
    always_comb
    begin
        digit       = mplier_reg[DIGIT_W-1:0];
        partial     = T_W'(mcand_reg) * T_W'($signed({1'b0, digit}));
        total       = T_W'(acc_reg) + partial;
        acc_next    = SUM_W'(total >>> DIGIT_W);
        sticky_next = sticky_reg | (|total[DIGIT_W-1:0]);
    end

    // Step sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            step_reg <= step_reg + 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= multiplicand;
            mplier_reg <= multiplier;
            acc_reg    <= '0;
            sticky_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            sticky_reg <= sticky_next;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = acc_reg;
    assign sticky      = sticky_reg;

endmodule

@@ rtl/cascaded_one_pole_highpass.sv @@
// Top level of the cascaded first-order high-pass filter with shared digit-serial multiplier.
// Each stage runs through S_LOAD, which forms the stage sum and starts the 4-bit-per-cycle multiplier,
// S_MUL, which waits for the product, and S_NEXT, which scales and saturates the stage result.
// The multiplier is shared by all stages. A new word is accepted the cycle after the result
// register is loaded, so only one word is in the filter at a time.
// Reset (asynchronous, active low) clears the coefficient, stage count and all stage history.
module cascaded_one_pole_highpass #(
    parameter int MAX_STAGES = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [chpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [chpf_pkg::CFG_DATA_W-1:0] cfg_data,
    chpf_sample_in_if.sink                         samples,
    chpf_sample_out_if.source                      results
);
    import chpf_pkg::*;

    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W = $clog2(MAX_STAGES + 1);
    localparam int Q_W   = ACC_W - FRAC_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_NEXT,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic        [ALPHA_W-1:0]  alpha_reg;
    logic        [COUNT_W-1:0]  stage_count_reg;
    logic        [IDX_W-1:0]    idx_reg;
    logic        [CNT_W-1:0]    last_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    logic signed [SAMPLE_W-1:0] x_prev_reg [MAX_STAGES];
    logic signed [ACC_W-1:0]    y_prev_reg [MAX_STAGES];

    logic                       in_accept;
    logic                       bypass;
    logic        [CNT_W-1:0]    n_eff;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SUM_W-1:0]    stage_sum;
    logic                       mul_start;
    mul_status_t                mul_st;
    logic signed [SUM_W-1:0]    mul_quot;
    logic                       mul_sticky;
    logic signed [SUM_W:0]      y_tz;
    logic        [SUM_W-ACC_W+1:0] y_top;
    logic signed [ACC_W-1:0]    y_sat;
    logic signed [ACC_W-1:0]    y_cur;
    logic signed [Q_W-1:0]      q_tz;
    logic        [Q_W-SAMPLE_W:0] q_top;
    logic signed [SAMPLE_W-1:0] q_sat;

    assign samples.ready  = (state_reg == S_IDLE);
    assign in_accept      = samples.valid && samples.ready;
    assign results.valid  = out_valid_reg;
    assign results.sample_out = out_sample_reg;

    // Stage count in use, clamped to the number of stages built.
    assign n_eff  = (int'(stage_count_reg) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                         : CNT_W'(stage_count_reg);
    assign bypass = (alpha_reg == '0) || (stage_count_reg == '0);

    // Stage sum y_prev + (x - x_prev) * 256 in Q.8.
    always_comb
    begin
        diff      = (SAMPLE_W+1)'(v_reg) - (SAMPLE_W+1)'(x_prev_reg[idx_reg]);
        stage_sum = SUM_W'(y_prev_reg[idx_reg]) + (SUM_W'(diff) <<< FRAC_W);
    end

    assign mul_start = (state_reg == S_LOAD);

    chpf_digit_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (stage_sum),
        .multiplier   (alpha_reg),
        .status       (mul_st),
        .quotient     (mul_quot),
        .sticky       (mul_sticky)
    );

    // Product / 65536 rounded toward zero, then saturated to the 32-bit history range.
    always_comb
    begin
        y_tz  = (SUM_W+1)'(mul_quot) + {{SUM_W{1'b0}}, mul_quot[SUM_W-1] & mul_sticky};
        y_top = y_tz[SUM_W:ACC_W-1];
        if ((&y_top) || !(|y_top))
        begin
            y_sat = y_tz[ACC_W-1:0];
        end
        else
        begin
            y_sat = y_tz[SUM_W] ? ACC_MIN : ACC_MAX;
        end
    end

    // Stage output: history / 256 rounded toward zero, saturated to 16 bits.
    always_comb
    begin
        y_cur = y_prev_reg[idx_reg];
        q_tz  = Q_W'(y_cur >>> FRAC_W)
              + {{(Q_W-1){1'b0}}, y_cur[ACC_W-1] & (|y_cur[FRAC_W-1:0])};
        q_top = q_tz[Q_W-1:SAMPLE_W-1];
        if ((&q_top) || !(|q_top))
        begin
            q_sat = q_tz[SAMPLE_W-1:0];
        end
        else
        begin
            q_sat = q_tz[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg       <= '0;
            stage_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHA:       alpha_reg       <= cfg_data[ALPHA_W-1:0];
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Per-stage history: input written when the stage starts, output when it ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                x_prev_reg[i] <= '0;
                y_prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_LOAD)
            begin
                x_prev_reg[idx_reg] <= v_reg;
            end
            if ((state_reg == S_MUL) && mul_st.done)
            begin
                y_prev_reg[idx_reg] <= y_sat;
            end
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg   <= '0;
                        last_reg  <= CNT_W'(n_eff - 1'b1);
                        state_reg <= bypass ? S_DONE : S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_st.done)
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (CNT_W'(idx_reg) == last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working sample and result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            v_reg <= samples.sample_in;
        end
        else if (state_reg == S_NEXT)
        begin
            v_reg <= q_sat;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || results.ready))
        begin
            out_sample_reg <= v_reg;
        end
    end

    // The multiplier reports completion only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_st.done |-> (state_reg == S_MUL))
        else $error("multiplier done outside the multiply state");

    // While waiting for the product, the multiplier is either working or finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (mul_st.busy || mul_st.done))
        else $error("sequencer waits on an idle multiplier");

    // The stage index never runs past the last stage in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (CNT_W'(idx_reg) <= last_reg))
        else $error("stage index beyond the stages in use");

    // A bypassed word goes straight to the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && bypass) |=> (state_reg == S_DONE))
        else $error("bypassed word entered the filter stages");

endmodule

@@ tb/chpf_checker.sv @@
// Checker that predicts every filtered word of the high-pass cascade and compares it.
`timescale 1ns / 1ps

module chpf_checker #(
    parameter int MAX_STAGES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [chpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chpf_pkg::CFG_DATA_W-1:0] cfg_data,
    chpf_sample_in_if                       in_ch,
    chpf_sample_out_if                      out_ch,
    output int                              fail_count,
    output int                              words_checked,
    output int                              words_pending
);
    import chpf_pkg::*;

    // Shadow copy of the coefficient, the stage count and the stage history.
    longint                     alpha_coef;
    logic [COUNT_W-1:0]         stage_cnt;
    logic signed [SAMPLE_W-1:0] prev_in [MAX_STAGES];
    logic signed [ACC_W-1:0]    prev_out [MAX_STAGES];

    // Filtered words still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] owed_words [$];
    logic signed [SAMPLE_W-1:0] want;

    // One RC stage: y = alpha * (y_prev + x - x_prev), kept in Q23.8 with saturation.
    function automatic logic signed [SAMPLE_W-1:0] hp_stage(int idx,
                                                           logic signed [SAMPLE_W-1:0] x);
        longint acc_sum;
        longint prod;
        longint y;
        longint o;
        acc_sum = longint'(prev_out[idx]) + (longint'(x) - longint'(prev_in[idx])) * 256;
        prod = alpha_coef * acc_sum;
        y = prod / 65536;
        if (y > longint'(ACC_MAX))
            y = longint'(ACC_MAX);
        else if (y < longint'(ACC_MIN))
            y = longint'(ACC_MIN);
        prev_in[idx] = x;
        prev_out[idx] = y[ACC_W-1:0];
        o = y / 256;
        if (o > longint'(SAMPLE_MAX))
            o = longint'(SAMPLE_MAX);
        else if (o < longint'(SAMPLE_MIN))
            o = longint'(SAMPLE_MIN);
        return o[SAMPLE_W-1:0];
    endfunction

    // Run a sample through the stages in use; bypass leaves the history untouched.
    function automatic logic signed [SAMPLE_W-1:0] filter_word(logic signed [SAMPLE_W-1:0] x);
        logic signed [SAMPLE_W-1:0] v;
        int n;
        v = x;
        n = (stage_cnt > MAX_STAGES) ? MAX_STAGES : int'(stage_cnt);
        if (alpha_coef != 0 && n != 0)
        begin
            for (int i = 0; i < n; i++)
                v = hp_stage(i, v);
        end
        return v;
    endfunction

    // Track register writes, check results against the oldest owed word, predict new words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_coef = 0;
            stage_cnt = '0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                prev_in[i] = '0;
                prev_out[i] = '0;
            end
            owed_words.delete();
            fail_count = 0;
            words_checked = 0;
            words_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA:       alpha_coef = longint'(cfg_data);
                    REG_STAGE_COUNT: stage_cnt = cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("sample_out with no word outstanding: expected none, got %0d",
                           out_ch.sample_out);
                    fail_count++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    words_checked++;
                    if (out_ch.sample_out !== want)
                    begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want, out_ch.sample_out);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                owed_words.push_back(filter_word(in_ch.sample_in));
            words_pending = owed_words.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the cascaded high-pass filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import chpf_pkg::*;

    localparam int NUM_STAGES  = 4;
    localparam int RANDOM_WORDS = 900;
    localparam int IDLE_LIMIT  = 4000;

    // Step and extreme sequence run at the sharpest setting.
    localparam logic signed [SAMPLE_W-1:0] STEP_SEQ [12] = '{
        16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0001,
        16'shFFFF, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    words_checked;
    int                    words_pending;
    int                    settings_used;
    int                    idle_cycles;
    bit                    quiet_phase;

    chpf_sample_in_if  samples_ch ();
    chpf_sample_out_if results_ch ();

    cascaded_one_pole_highpass #(
        .MAX_STAGES(NUM_STAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (samples_ch),
        .results  (results_ch)
    );

    chpf_checker #(
        .MAX_STAGES(NUM_STAGES)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (samples_ch),
        .out_ch       (results_ch),
        .fail_count   (fail_count),
        .words_checked(words_checked),
        .words_pending(words_pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long; none in quiet phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Next random sample: uniform noise, extremes, or a random walk like real audio.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(logic signed [SAMPLE_W-1:0] prev);
        int r;
        int w;
        r = $urandom_range(0, 9);
        if (r < 4)
            return SAMPLE_W'($urandom());
        if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_MIN;
                1:       return SAMPLE_MAX;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        w = int'(prev) + int'($urandom_range(0, 2047)) - 1024;
        if (w > 32767)
            w = 32767;
        else if (w < -32768)
            w = -32768;
        return w[SAMPLE_W-1:0];
    endfunction

    // Result side: ready with random stalls, held high in quiet phases.
    initial
    begin
        int stall;
        stall = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watchdog: too many cycles without any word moving or register written.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (samples_ch.valid && samples_ch.ready)
            || (results_ch.valid && results_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("cascaded_one_pole_highpass verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one word after an optional gap and wait until it is taken; ends at a falling edge.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid     <= 1'b1;
        samples_ch.sample_in <= value;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering words and wait until every owed result has come back.
    task automatic drain();
        samples_ch.valid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
    endtask

    // Single register write, one cycle wide; the write enable is then dropped again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Change the filter setting once the block is idle.
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] alpha_word,
                                 input logic [CFG_DATA_W-1:0] count_word);
        drain();
        write_reg(REG_ALPHA, alpha_word);
        write_reg(REG_STAGE_COUNT, count_word);
        settings_used++;
    endtask

    // Main stimulus.
    initial
    begin
        logic signed [SAMPLE_W-1:0] walk;
        logic [CFG_DATA_W-1:0]      a_word;
        logic [CFG_DATA_W-1:0]      c_word;
        int                         sent_random;
        int                         phase_len;
        int                         r;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        samples_ch.valid     = 1'b0;
        samples_ch.sample_in = '0;
        settings_used        = 1;
        quiet_phase          = 1'b0;
        walk                 = '0;
        sent_random          = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting bypasses the filter.
        send_word(SAMPLE_MIN);
        send_word(SAMPLE_MAX);
        send_word(16'sh0000);
        send_word(16'shFFFF);

        // Sharpest coefficient through all stages: steps, full swings, decay.
        apply_setting(16'hFFFF, 16'd4);
        foreach (STEP_SEQ[i])
            send_word(STEP_SEQ[i]);

        // Smallest nonzero coefficient on one stage.
        apply_setting(16'h0001, 16'd1);
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);

        // Zero coefficient bypasses even with stages selected.
        apply_setting(16'h0000, 16'd4);
        send_word(16'sd12345);
        send_word(SAMPLE_MIN);

        // Stage count above the maximum, with high data bits set, is clamped.
        apply_setting(16'd40000, 16'hFFFF);
        send_word(SAMPLE_MAX);
        send_word(16'sh0000);
        send_word(SAMPLE_MIN);

        // Writes to unused register indexes leave the setting alone.
        drain();
        write_reg(2'd2, CFG_DATA_W'($urandom()));
        write_reg(2'd3, CFG_DATA_W'($urandom()));
        send_word(16'sh4000);
        send_word(16'shC000);

        // Random phases, each with its own setting and idling style.
        while (sent_random < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                a_word = '0;
            else if (r == 1)
                a_word = 16'hFFFF;
            else if (r == 2)
                a_word = CFG_DATA_W'($urandom_range(1, 16));
            else
                a_word = CFG_DATA_W'($urandom());
            r = $urandom_range(0, 9);
            c_word = CFG_DATA_W'($urandom());
            if (r == 0)
                c_word[COUNT_W-1:0] = '0;
            else if (r == 9)
                c_word[COUNT_W-1:0] = COUNT_W'($urandom_range(5, 7));
            else
                c_word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, NUM_STAGES));
            apply_setting(a_word, c_word);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom()));
            quiet_phase = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(90, 130);
            repeat (phase_len)
            begin
                walk = next_sample(walk);
                send_word(walk);
                sent_random++;
            end
            quiet_phase = 1'b0;
        end

        // Let the last results come home, then a short tail.
        drain();
        repeat (40) @(posedge clk);
        $display("Run covered %0d filtered words over %0d filter settings,",
                 words_checked, settings_used);
        $display("with bypass, clamped stage counts and ignored register writes among them.");
        if (fail_count == 0 && words_pending == 0)
            $display("cascaded_one_pole_highpass verification clean");
        else
            $display("cascaded_one_pole_highpass verification failed");
        $finish;
    end

endmodule
